### hw/rtl/vipc_pkg.sv
package vipc_pkg;

    // vector set geometry: four 64-bit words, one bit per vector
    localparam int unsigned NumWords = 4;
    localparam int unsigned WordW    = 64;

    typedef logic [WordW-1:0] t_word;
    typedef logic [7:0]       t_vec;
    typedef logic [5:0]       t_pos;
    typedef logic [1:0]       t_widx;
    typedef logic [8:0]       t_rank;

    // architectural vectors
    localparam t_vec VecExtint   = 8'h00;
    localparam t_vec VecNmi      = 8'h02;
    localparam t_vec VecSpurious = 8'h0F;
    localparam t_vec VecFirstStd = 8'h10;

    // delivery modes that force a fixed vector
    localparam logic [2:0] ModeNmi    = 3'd4;
    localparam logic [2:0] ModeExtint = 3'd7;

    typedef enum logic [1:0] {
        REQ_PEND = 2'd0,
        REQ_ACK  = 2'd1,
        REQ_EOI  = 2'd2,
        REQ_EVAL = 2'd3
    } t_req;

    typedef enum logic {
        REG_MASK_ALL   = 1'b0,
        REG_MASK_CLASS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic       mask_all;
        logic [3:0] mask_class;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN_EOI,
        ST_CLR_EOI,
        ST_SCAN_IS,
        ST_SCAN_PEND,
        ST_EVAL
    } t_state;

    // vectors below 16 rank above all others
    function automatic t_rank rank_of(input t_vec v);
        t_rank r;
        if (v < VecFirstStd) begin
            r = {1'b1, v};
        end else begin
            r = {1'b0, v};
        end
        return r;
    endfunction

endpackage

### hw/rtl/vipc_in_if.sv
interface vipc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] vector;
    logic [2:0] delivery_mode;
    logic       interrupts_enabled;

    modport source (
        output valid, req_type, vector, delivery_mode, interrupts_enabled,
        input  ready
    );
    modport sink (
        input  valid, req_type, vector, delivery_mode, interrupts_enabled,
        output ready
    );
endinterface

### hw/rtl/vipc_out_if.sv
interface vipc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] current_vector;
    logic       take_interrupt;
    logic       request_dropped;

    modport source (
        output valid, current_vector, take_interrupt, request_dropped,
        input  ready
    );
    modport sink (
        input  valid, current_vector, take_interrupt, request_dropped,
        output ready
    );
endinterface

### hw/rtl/vipc_enc.sv
module vipc_enc
    import vipc_pkg::*;
(
    input  t_word i_word,
    output logic  o_any,
    output t_pos  o_pos
);

    // highest set bit of one 64-bit word
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < WordW; i++) begin
            if (i_word[i]) begin
                o_pos = t_pos'(i);
            end
        end
    end

    assign o_any = |i_word;

endmodule

### hw/rtl/vipc_regs.sv
module vipc_regs
    import vipc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    // register select: byte addresses 0 and 4
    assign idx    = t_reg_idx'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_all   <= 1'b1;
            r_cfg.mask_class <= 4'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MASK_ALL:   r_cfg.mask_all   <= pwdata[0];
                REG_MASK_CLASS: r_cfg.mask_class <= pwdata[3:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // read mux, low address bits ignored
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MASK_ALL:   prdata = {31'd0, r_cfg.mask_all};
            REG_MASK_CLASS: prdata = {28'd0, r_cfg.mask_class};
            default:        prdata = '0;
        endcase
    end

endmodule

### hw/rtl/vectored_interrupt_priority_controller.sv
// Vectored interrupt priority controller, 256 vectors.
// i_req carries one request transaction (pend, acknowledge, end of interrupt,
// re-evaluate); o_rsp returns exactly one transaction per request with the
// new current vector, the take_interrupt flag and the dropped-pend flag.
// The APB port sets mask_all (address 0) and mask_class (address 4); write
// it only while no request is in flight.
// Each request steps through apply, the in-service scan, the pending scan and
// evaluation. One shared 64-bit priority encoder scans the in-service set and
// then the pending set one word per cycle; end of interrupt adds one extra
// in-service scan plus a clear step. i_req.ready is high only between
// requests, so a new request is not accepted until the previous one ends.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits; a request finishes only once that
// register is free, so a stalled receiver holds the sequencer at its last step.
// Reset: pending and in-service sets cleared, current vector 15 (spurious),
// mask_all set, mask_class 0, no response valid.
module vectored_interrupt_priority_controller
    import vipc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    vipc_in_if.sink     i_req,
    vipc_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   cfg;
    t_state r_state, n_state;
    t_widx  r_cnt;

    t_req       r_req;
    t_vec       r_vec_in;
    logic [2:0] r_mode;
    logic       r_en;
    logic       r_drop;

    t_word r_pend [NumWords];
    t_word r_is   [NumWords];
    t_vec  r_cur;

    logic r_is_fnd, r_pd_fnd;
    t_vec r_is_top, r_pd_top;

    logic r_out_valid;
    t_vec r_out_vec;
    logic r_out_take;
    logic r_out_drop;

    // sequencer outputs
    logic accept, scan_pend, scan_is, out_free, eval_go;

    // shared encoder
    t_word enc_word;
    logic  enc_any;
    t_pos  enc_pos;

    // evaluation
    t_vec  pend_vec;
    logic  pend_drop;
    logic  cur_ok;
    logic  is_has;
    t_rank is_rank;
    logic  masked_ext, masked_top;
    t_vec  eval_vec;

    vipc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign enc_word = scan_pend ? r_pend[r_cnt] : r_is[r_cnt];

    vipc_enc u_enc (
        .i_word (enc_word),
        .o_any  (enc_any),
        .o_pos  (enc_pos)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_req.valid) n_state = ST_APPLY;
            ST_APPLY:     n_state = (r_req == REQ_EOI) ? ST_SCAN_EOI : ST_SCAN_IS;
            ST_SCAN_EOI:  if (r_cnt == 2'd0) n_state = ST_CLR_EOI;
            ST_CLR_EOI:   n_state = ST_SCAN_IS;
            ST_SCAN_IS:   if (r_cnt == 2'd0) n_state = ST_SCAN_PEND;
            ST_SCAN_PEND: if (r_cnt == 2'd0) n_state = ST_EVAL;
            ST_EVAL:      if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_req.ready = 1'b0;
        scan_pend   = 1'b0;
        scan_is     = 1'b0;
        unique case (r_state)
            ST_IDLE:      i_req.ready = 1'b1;
            ST_SCAN_EOI:  scan_is     = 1'b1;
            ST_SCAN_IS:   scan_is     = 1'b1;
            ST_SCAN_PEND: scan_pend   = 1'b1;
            default:      i_req.ready = 1'b0;
        endcase
    end

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign eval_go   = (r_state == ST_EVAL) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= t_req'(i_req.req_type);
            r_vec_in <= i_req.vector;
            r_mode   <= i_req.delivery_mode;
            r_en     <= i_req.interrupts_enabled;
        end
    end

    // word counter, wraps back to the top word after each scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd3;
        end else if (scan_is || scan_pend) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // scan result capture, restarted on the top word
    always_ff @(posedge i_clk) begin
        if (scan_is) begin
            if (r_cnt == 2'd3) begin
                r_is_fnd <= enc_any;
                r_is_top <= {r_cnt, enc_pos};
            end else if (!r_is_fnd && enc_any) begin
                r_is_fnd <= 1'b1;
                r_is_top <= {r_cnt, enc_pos};
            end
        end
        if (scan_pend) begin
            if (r_cnt == 2'd3) begin
                r_pd_fnd <= enc_any;
                r_pd_top <= {r_cnt, enc_pos};
            end else if (!r_pd_fnd && enc_any) begin
                r_pd_fnd <= 1'b1;
                r_pd_top <= {r_cnt, enc_pos};
            end
        end
    end

    // pend vector mapping and reserved-vector check
    always_comb begin
        if (r_mode == ModeNmi) begin
            pend_vec = VecNmi;
        end else if (r_mode == ModeExtint) begin
            pend_vec = VecExtint;
        end else begin
            pend_vec = r_vec_in;
        end
        pend_drop = (pend_vec < VecFirstStd) && (pend_vec != VecNmi)
                    && (pend_vec != VecExtint);
        cur_ok    = (r_cur >= VecFirstStd) || (r_cur == VecNmi) || (r_cur == VecExtint);
    end

    // pending and in-service sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NumWords; w++) begin
                r_pend[w] <= '0;
                r_is[w]   <= '0;
            end
            r_drop <= 1'b0;
        end else begin
            if (r_state == ST_APPLY) begin
                r_drop <= (r_req == REQ_PEND) && pend_drop;
                if (r_req == REQ_PEND && !pend_drop) begin
                    r_pend[pend_vec[7:6]][pend_vec[5:0]] <= 1'b1;
                end
                if (r_req == REQ_ACK && cur_ok) begin
                    r_pend[r_cur[7:6]][r_cur[5:0]] <= 1'b0;
                    r_is[r_cur[7:6]][r_cur[5:0]]   <= 1'b1;
                end
            end
            if (r_state == ST_CLR_EOI) begin
                if (r_is[0][VecNmi[5:0]]) begin
                    r_is[0][VecNmi[5:0]] <= 1'b0;
                end else if (r_is[0][VecExtint[5:0]]) begin
                    r_is[0][VecExtint[5:0]] <= 1'b0;
                end else if (r_is_fnd) begin
                    r_is[r_is_top[7:6]][r_is_top[5:0]] <= 1'b0;
                end
            end
        end
    end

    // highest in-service priority
    always_comb begin
        is_has = r_is[0][VecNmi[5:0]] || r_is[0][VecExtint[5:0]] || r_is_fnd;
        if (r_is[0][VecNmi[5:0]]) begin
            is_rank = rank_of(VecNmi);
        end else if (r_is[0][VecExtint[5:0]]) begin
            is_rank = rank_of(VecExtint);
        end else begin
            is_rank = rank_of(r_is_top);
        end
    end

    // masking and vector selection
    always_comb begin
        masked_ext = cfg.mask_all || (is_has && (is_rank >= rank_of(VecExtint)));
        masked_top = cfg.mask_all || (is_has && (is_rank >= rank_of(r_pd_top)))
                     || ((r_pd_top != VecExtint) && (r_pd_top[7:4] <= cfg.mask_class));
        if (r_pend[0][VecNmi[5:0]]) begin
            eval_vec = VecNmi;
        end else if (r_pend[0][VecExtint[5:0]] && !masked_ext) begin
            eval_vec = VecExtint;
        end else if (r_pd_fnd && !masked_top) begin
            eval_vec = r_pd_top;
        end else begin
            eval_vec = VecSpurious;
        end
    end

    // current vector register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= VecSpurious;
        end else if (eval_go) begin
            r_cur <= eval_vec;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_out_vec  <= eval_vec;
            r_out_take <= r_en && (eval_vec != VecSpurious);
            r_out_drop <= r_drop;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.current_vector  = r_out_vec;
    assign o_rsp.take_interrupt  = r_out_take;
    assign o_rsp.request_dropped = r_out_drop;

`ifndef SYNTHESIS
    // current vector never holds a reserved vector other than the spurious vector
    a_cur_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur >= VecFirstStd) || (r_cur == VecNmi) || (r_cur == VecExtint)
        || (r_cur == VecSpurious))
        else $error("current vector holds a reserved vector");

    // reserved vectors never enter the pending or in-service sets
    a_no_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend[0][15:3] == '0) && !r_pend[0][1] && (r_is[0][15:3] == '0) && !r_is[0][1])
        else $error("reserved vector set in pending or in-service");

    // an accepted request starts the sequence
    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_APPLY))
        else $error("accepted request did not start the sequence");

    // the scans after apply and after the end-of-interrupt clear begin on the top word
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_APPLY) || (r_state == ST_CLR_EOI)) |-> (r_cnt == 2'd3))
        else $error("scan counter not at top word");

    // the response register is only loaded when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_vec == $past(r_out_vec)))
        else $error("pending response overwritten");
`endif

endmodule
